[hdl/hsvc_pkg.sv]
// Shared types, constants and register codes of the HSV colour classifier.
`timescale 1ns / 1ps

package hsvc_pkg;

	localparam int PIX_W           = 8;
	localparam int TOTAL_W         = 24;
	localparam int COUNT_WIDTH_DEF = 24;
	localparam int CFG_DATA_W      = 32;
	localparam int CFG_ADDR_W      = 5;

	// fixed point used by the HSV conversion
	localparam int FIX_SHIFT   = 12;
	localparam int FIX_HALF    = 2048;
	localparam int SAT_NUM     = 255 * 4096;
	localparam int HUE_NUM     = 30 * 4096;
	localparam int SAT_RECIP_W = 20;
	localparam int HUE_RECIP_W = 17;
	localparam int HUE_SPAN    = 180;

	// queue sizes (powers of two)
	localparam int CLS_DEPTH = 8;
	localparam int RES_DEPTH = 2;

	// reset values of the registers
	localparam logic [7:0]  RST_RED_SAT_VAL_MIN   = 8'd150;
	localparam logic [7:0]  RST_RED_LOW_HUE_MAX   = 8'd10;
	localparam logic [7:0]  RST_RED_HIGH_HUE_MIN  = 8'd160;
	localparam logic [7:0]  RST_GREEN_HUE_MIN     = 8'd20;
	localparam logic [7:0]  RST_GREEN_HUE_MAX     = 8'd80;
	localparam logic [7:0]  RST_GREEN_SAT_VAL_MIN = 8'd50;
	localparam logic [23:0] RST_PIXEL_COUNT_MIN   = 24'd500;

	typedef enum logic [2:0] {
		REG_RED_SAT_VAL_MIN   = 3'd0,
		REG_RED_LOW_HUE_MAX   = 3'd1,
		REG_RED_HIGH_HUE_MIN  = 3'd2,
		REG_GREEN_HUE_MIN     = 3'd3,
		REG_GREEN_HUE_MAX     = 3'd4,
		REG_GREEN_SAT_VAL_MIN = 3'd5,
		REG_PIXEL_COUNT_MIN   = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		CLASS_UNKNOWN = 2'd0,
		CLASS_RED     = 2'd1,
		CLASS_GREEN   = 2'd2
	} color_class_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green_in;
		logic [7:0] red_in;
		logic       frame_end;
	} pixel_t;

	typedef struct packed {
		color_class_t  color_class;
		logic [23:0]   red_total;
		logic [23:0]   green_total;
	} result_t;

	// thresholds seen by the front end
	typedef struct packed {
		logic [7:0] red_sat_val_min;
		logic [7:0] red_low_hue_max;
		logic [7:0] red_high_hue_min;
		logic [7:0] green_hue_min;
		logic [7:0] green_hue_max;
		logic [7:0] green_sat_val_min;
	} thresh_t;

	// one classified pixel travelling from front to back
	typedef struct packed {
		logic is_red;
		logic is_green;
		logic frame_end;
	} cls_item_t;

endpackage

[hdl/hsvc_fifo.sv]
// Small register-based FIFO used for the class queue and the result queue.
`timescale 1ns / 1ps

module hsvc_fifo #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 8  // power of two
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	output logic                       full,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem[rd_ptr_q];
	assign count   = count_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_fill_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("fifo fill level did not follow a lone push");

endmodule

[hdl/hsvc_front.sv]
// Front end: BGR to HSV conversion and per-pixel red/green tests, five stages.
`timescale 1ns / 1ps

module hsvc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  hsvc_pkg::pixel_t     pixel,
	input  hsvc_pkg::thresh_t    thr,
	output logic                 out_valid,
	output hsvc_pkg::cls_item_t  out_item,
	output logic [2:0]           inflight
);
	import hsvc_pkg::*;

	localparam int TAB_N = 1 << PIX_W;

	// reciprocal tables, built at elaboration
	logic [SAT_RECIP_W-1:0] sat_tab [TAB_N];
	logic [HUE_RECIP_W-1:0] hue_tab [TAB_N];

	for (genvar i = 0; i < TAB_N; i++) begin : g_tab
		localparam int DEN = (i == 0) ? 1 : 2 * i;
		localparam int SR  = (i == 0) ? 0 : (2 * SAT_NUM + i) / DEN;
		localparam int HR  = (i == 0) ? 0 : (2 * HUE_NUM + i) / DEN;
		assign sat_tab[i] = SAT_RECIP_W'(SR);
		assign hue_tab[i] = HUE_RECIP_W'(HR);
	end

	// stage 1: max, min, spread and hue numerator
	logic [7:0]         mx, mn, diff;
	logic signed [11:0] sb, sg, sr, sd, hnum;
	logic               valid_s1, fe_s1;
	logic [7:0]         v_s1, diff_s1;
	logic signed [11:0] hnum_s1;

	always_comb begin
		mx = pixel.blue;
		mn = pixel.blue;
		if (pixel.green_in > mx) mx = pixel.green_in;
		if (pixel.red_in > mx)   mx = pixel.red_in;
		if (pixel.green_in < mn) mn = pixel.green_in;
		if (pixel.red_in < mn)   mn = pixel.red_in;
		diff = mx - mn;
		sb   = $signed({4'b0000, pixel.blue});
		sg   = $signed({4'b0000, pixel.green_in});
		sr   = $signed({4'b0000, pixel.red_in});
		sd   = $signed({4'b0000, diff});
		if (mx == pixel.red_in) begin
			hnum = sg - sb;
		end else if (mx == pixel.green_in) begin
			hnum = sb - sr + (sd <<< 1);
		end else begin
			hnum = sr - sg + (sd <<< 2);
		end
	end

	// stage 2: table look-ups
	logic                   valid_s2, fe_s2;
	logic [7:0]             v_s2, diff_s2;
	logic signed [11:0]     hnum_s2;
	logic [SAT_RECIP_W-1:0] srec_s2;
	logic [HUE_RECIP_W-1:0] hrec_s2;

	// stage 3: products
	logic                   valid_s3, fe_s3;
	logic [7:0]             v_s3;
	logic [27:0]            sprod_s3;
	logic signed [29:0]     hprod_s3;

	// stage 4: rounded S and H
	logic [28:0]            ssum;
	logic signed [29:0]     hsum, hshift;
	logic [9:0]             hraw, hwrap;
	logic                   valid_s4, fe_s4;
	logic [7:0]             v_s4;
	logic [8:0]             s_s4, h_s4;

	always_comb begin
		ssum   = {1'b0, sprod_s3} + 29'(FIX_HALF);
		hsum   = hprod_s3 + $signed(30'(FIX_HALF));
		hshift = hsum >>> FIX_SHIFT;
		hraw   = hshift[9:0];
		hwrap  = hraw[9] ? (hraw + 10'(HUE_SPAN)) : hraw;
	end

	// stage 5: band tests
	logic is_red, is_green;
	logic valid_s5;
	cls_item_t item_s5;

	always_comb begin
		is_red = (s_s4 >= {1'b0, thr.red_sat_val_min}) && (v_s4 >= thr.red_sat_val_min) &&
			((h_s4 <= {1'b0, thr.red_low_hue_max}) ||
			 ((h_s4 >= {1'b0, thr.red_high_hue_min}) && (h_s4 <= 9'(HUE_SPAN))));
		is_green = (s_s4 >= {1'b0, thr.green_sat_val_min}) &&
			(v_s4 >= thr.green_sat_val_min) &&
			(h_s4 >= {1'b0, thr.green_hue_min}) && (h_s4 <= {1'b0, thr.green_hue_max});
	end

	always_ff @(posedge clk) begin
		fe_s1    <= pixel.frame_end;
		v_s1     <= mx;
		diff_s1  <= diff;
		hnum_s1  <= hnum;

		fe_s2    <= fe_s1;
		v_s2     <= v_s1;
		diff_s2  <= diff_s1;
		hnum_s2  <= hnum_s1;
		srec_s2  <= sat_tab[v_s1];
		hrec_s2  <= hue_tab[diff_s1];

		fe_s3    <= fe_s2;
		v_s3     <= v_s2;
		sprod_s3 <= diff_s2 * srec_s2;
		hprod_s3 <= hnum_s2 * $signed({1'b0, hrec_s2});

		fe_s4    <= fe_s3;
		v_s4     <= v_s3;
		s_s4     <= ssum[FIX_SHIFT+8:FIX_SHIFT];
		h_s4     <= hwrap[8:0];

		item_s5.is_red    <= is_red;
		item_s5.is_green  <= is_green;
		item_s5.frame_end <= fe_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	assign out_valid = valid_s5;
	assign out_item  = item_s5;
	assign inflight  = 3'($countones({valid_s1, valid_s2, valid_s3, valid_s4, valid_s5}));

endmodule

[hdl/hsvc_back.sv]
// Back end: saturating colour counters and the end-of-frame decision.
`timescale 1ns / 1ps

module hsvc_back #(
	parameter int COUNT_WIDTH = hsvc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  hsvc_pkg::cls_item_t  q_item,
	output logic                 q_pop,
	input  logic [23:0]          count_min,
	input  logic                 res_full,
	output logic                 res_push,
	output hsvc_pkg::result_t    res_item
);
	import hsvc_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;

	logic [COUNT_WIDTH-1:0] red_cnt_q, green_cnt_q;
	logic [COUNT_WIDTH-1:0] red_next, green_next;
	logic [COUNT_WIDTH-1:0] dec_red_s1, dec_green_s1;
	logic                   dec_valid_s1, dec_free;
	logic [CMP_W-1:0]       red_ext, green_ext, min_ext;

	always_comb begin
		red_next   = red_cnt_q;
		green_next = green_cnt_q;
		if (q_item.is_red && (red_cnt_q != '1)) begin
			red_next = red_cnt_q + 1'b1;
		end
		if (q_item.is_green && (green_cnt_q != '1)) begin
			green_next = green_cnt_q + 1'b1;
		end
	end

	assign res_push = dec_valid_s1 && !res_full;
	assign dec_free = !dec_valid_s1 || res_push;
	// a frame end waits until the decision stage can take it
	assign q_pop    = !q_empty && (!q_item.frame_end || dec_free);

	always_ff @(posedge clk) begin
		if (q_pop && q_item.frame_end) begin
			dec_red_s1   <= red_next;
			dec_green_s1 <= green_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_cnt_q    <= '0;
			green_cnt_q  <= '0;
			dec_valid_s1 <= 1'b0;
		end else begin
			if (q_pop) begin
				if (q_item.frame_end) begin
					red_cnt_q   <= '0;
					green_cnt_q <= '0;
				end else begin
					red_cnt_q   <= red_next;
					green_cnt_q <= green_next;
				end
			end
			if (q_pop && q_item.frame_end) begin
				dec_valid_s1 <= 1'b1;
			end else if (res_push) begin
				dec_valid_s1 <= 1'b0;
			end
		end
	end

	always_comb begin
		red_ext   = CMP_W'(dec_red_s1);
		green_ext = CMP_W'(dec_green_s1);
		min_ext   = CMP_W'(count_min);
		if ((red_ext > green_ext) && (red_ext > min_ext)) begin
			res_item.color_class = CLASS_RED;
		end else if (green_ext > min_ext) begin
			res_item.color_class = CLASS_GREEN;
		end else begin
			res_item.color_class = CLASS_UNKNOWN;
		end
		res_item.red_total   = red_ext[TOTAL_W-1:0];
		res_item.green_total = green_ext[TOTAL_W-1:0];
	end

	a_clear_on_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_item.frame_end) |=> (red_cnt_q == '0) && (green_cnt_q == '0))
		else $error("counters not cleared after frame end");

	a_dec_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_item.frame_end) |=> dec_valid_s1)
		else $error("frame end item lost before decision stage");

endmodule

[hdl/hsv_color_light_classifier.sv]
// Top level of the HSV colour classifier: register file, front end, queues, back end.
`timescale 1ns / 1ps

// Takes one BGR pixel per clock, while full is low, through a push/full queue
// port and returns one result per frame through an empty/pop port. Each pixel
// is converted to HSV (hue in half degrees, saturation and value 0..255,
// rounded to nearest) in a five-stage front pipeline, tested against the red
// and green bands, and the verdict goes into an 8-entry class queue. The back
// end drains that queue one item a clock, keeping saturating red and green
// counts, but a frame_end item waits for a free decision register; on a
// frame_end pixel it latches the counts there, clears them, decides the class
// and writes a result into a 2-entry result queue once that has room.
// Sustained rate is one pixel per clock while results are taken. full rises
// when the class queue plus the pixels still in the front pipeline would
// fill the eight class-queue entries; with the result queue full, a frame_end
// item stalls in the class queue and that backs up to full. Registers sit on
// the APB port at byte addresses 4*index (0 red S/V min, 1 red low-band top,
// 2 red high-band bottom, 3 green band bottom, 4 green band top, 5 green S/V
// min, 6 pixel count minimum); write them only while no item is in flight.
module hsv_color_light_classifier #(
	parameter int COUNT_WIDTH = hsvc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [hsvc_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [hsvc_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [hsvc_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready,
	// pixel input
	input  logic                              push,
	output logic                              full,
	input  hsvc_pkg::pixel_t                  pixel,
	// result output
	input  logic                              pop,
	output logic                              empty,
	output hsvc_pkg::result_t                 result
);
	import hsvc_pkg::*;

	localparam int CLS_W     = $bits(cls_item_t);
	localparam int RES_W     = $bits(result_t);
	localparam int CLS_CNT_W = $clog2(CLS_DEPTH + 1);

	// ---------------- register file ----------------
	logic [7:0]  red_sat_val_min_q, red_low_hue_max_q, red_high_hue_min_q;
	logic [7:0]  green_hue_min_q, green_hue_max_q, green_sat_val_min_q;
	logic [23:0] pixel_count_min_q;
	logic        cfg_wr;
	reg_idx_t    cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_sat_val_min_q   <= RST_RED_SAT_VAL_MIN;
			red_low_hue_max_q   <= RST_RED_LOW_HUE_MAX;
			red_high_hue_min_q  <= RST_RED_HIGH_HUE_MIN;
			green_hue_min_q     <= RST_GREEN_HUE_MIN;
			green_hue_max_q     <= RST_GREEN_HUE_MAX;
			green_sat_val_min_q <= RST_GREEN_SAT_VAL_MIN;
			pixel_count_min_q   <= RST_PIXEL_COUNT_MIN;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_RED_SAT_VAL_MIN:   red_sat_val_min_q   <= pwdata[7:0];
				REG_RED_LOW_HUE_MAX:   red_low_hue_max_q   <= pwdata[7:0];
				REG_RED_HIGH_HUE_MIN:  red_high_hue_min_q  <= pwdata[7:0];
				REG_GREEN_HUE_MIN:     green_hue_min_q     <= pwdata[7:0];
				REG_GREEN_HUE_MAX:     green_hue_max_q     <= pwdata[7:0];
				REG_GREEN_SAT_VAL_MIN: green_sat_val_min_q <= pwdata[7:0];
				REG_PIXEL_COUNT_MIN:   pixel_count_min_q   <= pwdata[23:0];
				default: ; // unmapped index: write dropped
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_RED_SAT_VAL_MIN:   prdata = CFG_DATA_W'(red_sat_val_min_q);
			REG_RED_LOW_HUE_MAX:   prdata = CFG_DATA_W'(red_low_hue_max_q);
			REG_RED_HIGH_HUE_MIN:  prdata = CFG_DATA_W'(red_high_hue_min_q);
			REG_GREEN_HUE_MIN:     prdata = CFG_DATA_W'(green_hue_min_q);
			REG_GREEN_HUE_MAX:     prdata = CFG_DATA_W'(green_hue_max_q);
			REG_GREEN_SAT_VAL_MIN: prdata = CFG_DATA_W'(green_sat_val_min_q);
			REG_PIXEL_COUNT_MIN:   prdata = CFG_DATA_W'(pixel_count_min_q);
			default:               prdata = '0;
		endcase
	end

	thresh_t thr;

	always_comb begin
		thr.red_sat_val_min   = red_sat_val_min_q;
		thr.red_low_hue_max   = red_low_hue_max_q;
		thr.red_high_hue_min  = red_high_hue_min_q;
		thr.green_hue_min     = green_hue_min_q;
		thr.green_hue_max     = green_hue_max_q;
		thr.green_sat_val_min = green_sat_val_min_q;
	end

	// ---------------- front end ----------------
	logic            accept;
	logic            fr_valid;
	cls_item_t       fr_item;
	logic [2:0]      fr_inflight;
	logic [CLS_CNT_W:0] reserved;
	logic [CLS_CNT_W-1:0] cls_count;

	// the front pipeline never stalls, so every item in it holds a class-queue slot
	assign reserved = {1'b0, cls_count} + (CLS_CNT_W + 1)'(fr_inflight);
	assign full     = (reserved >= (CLS_CNT_W + 1)'(CLS_DEPTH));
	assign accept   = push && !full;

	hsvc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.pixel    (pixel),
		.thr      (thr),
		.out_valid(fr_valid),
		.out_item (fr_item),
		.inflight (fr_inflight)
	);

	// ---------------- class queue ----------------
	logic [CLS_W-1:0]     cls_rdata;
	logic                 cls_full, cls_empty, cls_pop;

	hsvc_fifo #(
		.WIDTH(CLS_W),
		.DEPTH(CLS_DEPTH)
	) u_cls_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fr_valid),
		.wdata (fr_item),
		.full  (cls_full),
		.pop   (cls_pop),
		.rdata (cls_rdata),
		.empty (cls_empty),
		.count (cls_count)
	);

	// ---------------- back end ----------------
	logic    res_full, res_push;
	result_t res_item;

	hsvc_back #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (cls_empty),
		.q_item   (cls_item_t'(cls_rdata)),
		.q_pop    (cls_pop),
		.count_min(pixel_count_min_q),
		.res_full (res_full),
		.res_push (res_push),
		.res_item (res_item)
	);

	// ---------------- result queue ----------------
	logic [RES_W-1:0]                 res_rdata;
	logic [$clog2(RES_DEPTH+1)-1:0]   res_count;

	hsvc_fifo #(
		.WIDTH(RES_W),
		.DEPTH(RES_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_item),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_rdata),
		.empty (empty),
		.count (res_count)
	);

	assign result = result_t'(res_rdata);

	a_cls_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fr_valid |-> !cls_full)
		else $error("front end delivered an item into a full class queue");

	a_res_count_ok: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> (res_count == '0))
		else $error("result queue empty flag disagrees with its fill level");

endmodule

[sim/hsvc_frame_checker.sv]
// Port monitor and frame-result predictor for the HSV colour classifier.
`timescale 1ns / 1ps

module hsvc_frame_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [hsvc_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [hsvc_pkg::CFG_DATA_W-1:0] pwdata,
	input  logic                            pready,
	input  logic                            push,
	input  logic                            full,
	input  hsvc_pkg::pixel_t                pixel,
	input  logic                            pop,
	input  logic                            empty,
	input  hsvc_pkg::result_t               result,
	output int                              pending,
	output int                              errors,
	output int                              pixels_seen,
	output int                              frames_seen
);
	import hsvc_pkg::*;

	typedef struct packed {
		int hue;
		int sat;
		int val;
	} hsv_t;

	// shadow thresholds
	logic [7:0]  red_sv, red_lo, red_hi, grn_lo, grn_hi, grn_sv;
	logic [23:0] count_min;

	logic [23:0] red_cnt, grn_cnt;
	result_t     frame_results_due[$];

	hsv_t        hsv;
	logic        is_red, is_green;
	result_t     due;

	// floor(x / 4096), also for negative x
	function automatic int fix_floor(int x);
		if (x >= 0)
			return x >>> FIX_SHIFT;
		return -((-x + 4095) >>> FIX_SHIFT);
	endfunction

	function automatic hsv_t pixel_hsv(int b, int g, int r);
		int   mx, mn, diff, hh, srec, hrec;
		hsv_t res;
		mx = b;
		mn = b;
		if (g > mx) mx = g;
		if (r > mx) mx = r;
		if (g < mn) mn = g;
		if (r < mn) mn = r;
		diff = mx - mn;
		srec = (mx == 0) ? 0 : (2 * SAT_NUM + mx) / (2 * mx);
		hrec = (diff == 0) ? 0 : (2 * HUE_NUM + diff) / (2 * diff);
		res.val = mx;
		res.sat = fix_floor(diff * srec + FIX_HALF);
		if (mx == r)
			hh = g - b;
		else if (mx == g)
			hh = b - r + 2 * diff;
		else
			hh = r - g + 4 * diff;
		hh = fix_floor(hh * hrec + FIX_HALF);
		if (hh < 0)
			hh += HUE_SPAN;
		res.hue = hh;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_sv      = RST_RED_SAT_VAL_MIN;
			red_lo      = RST_RED_LOW_HUE_MAX;
			red_hi      = RST_RED_HIGH_HUE_MIN;
			grn_lo      = RST_GREEN_HUE_MIN;
			grn_hi      = RST_GREEN_HUE_MAX;
			grn_sv      = RST_GREEN_SAT_VAL_MIN;
			count_min   = RST_PIXEL_COUNT_MIN;
			red_cnt     = '0;
			grn_cnt     = '0;
			frame_results_due.delete();
			pending     = 0;
			errors      = 0;
			pixels_seen = 0;
			frames_seen = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[CFG_ADDR_W-1:2])
					REG_RED_SAT_VAL_MIN:   red_sv    = pwdata[7:0];
					REG_RED_LOW_HUE_MAX:   red_lo    = pwdata[7:0];
					REG_RED_HIGH_HUE_MIN:  red_hi    = pwdata[7:0];
					REG_GREEN_HUE_MIN:     grn_lo    = pwdata[7:0];
					REG_GREEN_HUE_MAX:     grn_hi    = pwdata[7:0];
					REG_GREEN_SAT_VAL_MIN: grn_sv    = pwdata[7:0];
					REG_PIXEL_COUNT_MIN:   count_min = pwdata[23:0];
					default: ;
				endcase
			end

			if (pop && !empty) begin
				if (frame_results_due.size() == 0) begin
					$error("result with no frame pending: class %0d red %0d green %0d",
						result.color_class, result.red_total, result.green_total);
					errors++;
				end else begin
					due = frame_results_due.pop_front();
					frames_seen++;
					if (result.color_class !== due.color_class) begin
						$error("color_class: expected %0d, got %0d",
							due.color_class, result.color_class);
						errors++;
					end
					if (result.red_total !== due.red_total) begin
						$error("red_total: expected %0d, got %0d",
							due.red_total, result.red_total);
						errors++;
					end
					if (result.green_total !== due.green_total) begin
						$error("green_total: expected %0d, got %0d",
							due.green_total, result.green_total);
						errors++;
					end
				end
			end

			if (push && !full) begin
				pixels_seen++;
				hsv = pixel_hsv(pixel.blue, pixel.green_in, pixel.red_in);
				is_red = hsv.sat >= int'(red_sv) && hsv.val >= int'(red_sv) &&
					(hsv.hue <= int'(red_lo) ||
					 (hsv.hue >= int'(red_hi) && hsv.hue <= HUE_SPAN));
				is_green = hsv.sat >= int'(grn_sv) && hsv.val >= int'(grn_sv) &&
					hsv.hue >= int'(grn_lo) && hsv.hue <= int'(grn_hi);
				if (is_red && red_cnt != '1)
					red_cnt = red_cnt + 1'b1;
				if (is_green && grn_cnt != '1)
					grn_cnt = grn_cnt + 1'b1;
				if (pixel.frame_end) begin
					if (red_cnt > grn_cnt && red_cnt > count_min)
						due.color_class = CLASS_RED;
					else if (grn_cnt > count_min)
						due.color_class = CLASS_GREEN;
					else
						due.color_class = CLASS_UNKNOWN;
					due.red_total   = red_cnt;
					due.green_total = grn_cnt;
					frame_results_due.push_back(due);
					red_cnt = '0;
					grn_cnt = '0;
				end
			end

			pending = frame_results_due.size();
		end
	end

endmodule

[sim/hsv_color_light_classifier_tb.sv]
// Testbench top for the HSV colour classifier: stimulus, threshold writes, verdict.
`timescale 1ns / 1ps

module hsv_color_light_classifier_tb;
	import hsvc_pkg::*;

	localparam int CLK_PERIOD    = 12;
	localparam int LIMIT_CYCLES  = 300000;  // far beyond the slowest legal run
	localparam int SETTLE_CYCLES = 24;      // front pipe + class/result queues, with margin
	localparam int HOLD_CYCLES   = 300;     // long result hold-off to back up the input
	localparam logic [2:0] REG_UNUSED = 3'd7;  // past the register file; writes are dropped

	logic                  clk;
	logic                  arst_n;
	logic                  psel, penable, pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata, prdata;
	logic                  pready;
	logic                  push, full;
	pixel_t                pixel;
	logic                  pop, empty;
	result_t               result;

	int   pending, errors, pixels_seen, frames_seen;
	int   idle_pct, stall_pct;   // per-cycle chance of a sender gap / receiver stall
	logic hold_pop;
	int   thresh_sets;

	hsv_color_light_classifier dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.push    (push),
		.full    (full),
		.pixel   (pixel),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

	hsvc_frame_checker frame_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.push        (push),
		.full        (full),
		.pixel       (pixel),
		.pop         (pop),
		.empty       (empty),
		.result      (result),
		.pending     (pending),
		.errors      (errors),
		.pixels_seen (pixels_seen),
		.frames_seen (frames_seen)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// Receiver: pops at random unless a hold-off is running. pop may stay high
	// while empty; only pop with empty low takes a result.
	always @(posedge clk)
		pop <= !hold_pop && ($urandom_range(99) >= stall_pct);

	// Watchdog: a hang or a lost result ends here.
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("Mismatches found");
		$finish;
	end

	function automatic pixel_t mk_pixel(int b, int g, int r, int fe);
		pixel_t p;
		p.blue      = b[7:0];
		p.green_in  = g[7:0];
		p.red_in    = r[7:0];
		p.frame_end = fe[0];
		return p;
	endfunction

	// Saturated pixel: one strong channel, one weak, the third in between, so
	// hues sweep the whole circle with S and V high enough to hit the bands.
	function automatic pixel_t colour_pixel();
		logic [7:0] ch [3];
		int         hi, lo;
		pixel_t     p;
		hi         = $urandom_range(0, 2);
		lo         = (hi + $urandom_range(1, 2)) % 3;
		ch[hi]     = 8'($urandom_range(120, 255));
		ch[lo]     = 8'($urandom_range(0, 70));
		ch[3 - hi - lo] = 8'($urandom_range(ch[lo], ch[hi]));
		p.blue      = ch[0];
		p.green_in  = ch[1];
		p.red_in    = ch[2];
		p.frame_end = 1'b0;
		return p;
	endfunction

	// Offer one item and hold it until taken. Entered and left at a rising edge;
	// push is lowered only for a gap, never lowered and raised in one step.
	task automatic send_pixel(pixel_t p);
		while ($urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push  <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (full);
	endtask

	// Let every expected frame result drain, then give the pipe time to settle
	// so pixels without frame_end are classified before thresholds move.
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle then access cycle, done on the edge with pready,
	// then the bus goes back to idle before the next transfer.
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_thresholds(int rsv, int rlo, int rhi, int glo, int ghi, int gsv,
		int cmin);
		write_reg(REG_RED_SAT_VAL_MIN, rsv);
		write_reg(REG_RED_LOW_HUE_MAX, rlo);
		write_reg(REG_RED_HIGH_HUE_MIN, rhi);
		write_reg(REG_GREEN_HUE_MIN, glo);
		write_reg(REG_GREEN_HUE_MAX, ghi);
		write_reg(REG_GREEN_SAT_VAL_MIN, gsv);
		write_reg(REG_PIXEL_COUNT_MIN, cmin);
		thresh_sets++;
	endtask

	// Random thresholds near the usual bands. The green band is sometimes
	// inverted (matches nothing); the count minimum is mostly tiny so all
	// three classes come up in short frames. Junk above each field checks masking.
	task automatic random_thresholds();
		int glo, ghi, cmin;
		glo  = $urandom_range(0, 90);
		ghi  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 179) : glo + $urandom_range(0, 90);
		cmin = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 4);
		set_thresholds(($urandom() << 8) | $urandom_range(0, 200),
			($urandom() << 8) | $urandom_range(0, 30),
			($urandom() << 8) | $urandom_range(140, 179),
			($urandom() << 8) | glo,
			($urandom() << 8) | ghi,
			($urandom() << 8) | $urandom_range(0, 200),
			($urandom() << 24) | (cmin & 32'hFF_FFFF));
	endtask

	// Frames of random length, mostly saturated colours, some plain noise and
	// the odd stray frame_end that cuts a frame short.
	task automatic run_frames(int n);
		int          left, len;
		pixel_t      p;
		logic [31:0] rnd;
		left = n;
		while (left > 0) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			if (len > left)
				len = left;
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 9) < 7) begin
					p = colour_pixel();
				end else begin
					rnd = $urandom();
					p   = rnd[$bits(pixel_t)-1:0];
				end
				p.frame_end = (i == len - 1) || ($urandom_range(0, 19) == 0);
				send_pixel(p);
			end
			left -= len;
		end
	endtask

	task automatic hold_results();
		hold_pop <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_pop <= 1'b0;
	endtask

	initial begin
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		push        = 1'b0;
		pixel       = '0;
		pop         = 1'b0;
		hold_pop    = 1'b0;
		idle_pct    = 0;
		stall_pct   = 0;
		thresh_sets = 1;  // the reset values count as the first set
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset thresholds: the corners of the conversion. Black and
		// white, a grey (max equals min), the primaries, yellow and cyan where
		// two channels tie for max, and red-magenta pixels whose raw hue is
		// negative and wraps past 180 (or rounds back to 0).
		send_pixel(mk_pixel(0, 0, 0, 0));
		send_pixel(mk_pixel(255, 255, 255, 0));
		send_pixel(mk_pixel(128, 128, 128, 0));
		send_pixel(mk_pixel(0, 0, 255, 0));
		send_pixel(mk_pixel(0, 255, 0, 0));
		send_pixel(mk_pixel(255, 0, 0, 0));
		send_pixel(mk_pixel(0, 255, 255, 0));
		send_pixel(mk_pixel(200, 0, 255, 0));
		send_pixel(mk_pixel(255, 255, 0, 0));
		send_pixel(mk_pixel(1, 0, 255, 1));

		// count minimum of one so short frames reach a decision
		drain();
		write_reg(REG_PIXEL_COUNT_MIN, 1);
		// red majority
		send_pixel(mk_pixel(0, 0, 255, 0));
		send_pixel(mk_pixel(0, 0, 255, 0));
		send_pixel(mk_pixel(0, 0, 255, 0));
		send_pixel(mk_pixel(20, 0, 200, 1));
		// red equals green: red loses the tie, green wins
		send_pixel(mk_pixel(0, 200, 0, 0));
		send_pixel(mk_pixel(40, 255, 30, 0));
		send_pixel(mk_pixel(0, 0, 255, 0));
		send_pixel(mk_pixel(10, 5, 250, 0));
		send_pixel(mk_pixel(0, 0, 0, 1));
		// single-pixel frame, nothing counted
		send_pixel(mk_pixel(0, 0, 0, 1));

		// Random phases, each with its own thresholds and idling pattern.
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			case (ph)
				0: set_thresholds(0, 0, 0, 0, 0, 0, 0);
				1: set_thresholds(255, 255, 255, 255, 255, 255, 32'hFF_FFFF);
				2: set_thresholds(100, 40, 150, 30, 170, 60, 2);  // bands overlap
				3: begin
					write_reg(REG_UNUSED, $urandom());
					random_thresholds();
				end
				default: random_thresholds();
			endcase
			case (ph)
				1: begin
					idle_pct  = 83;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 83;
				end
				3: begin
					idle_pct  = 6;
					stall_pct = 6;
				end
				default: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
			endcase
			run_frames(70);
		end

		// Back-pressure: results held for a long stretch while one-pixel frames
		// keep coming, so the result queue fills, frame_end items pile up in the
		// class queue and full has to stall the sender.
		drain();
		random_thresholds();
		idle_pct  = 0;
		stall_pct = 0;
		fork
			hold_results();
			for (int i = 0; i < 40; i++) begin
				send_pixel(mk_pixel($urandom(), $urandom(), $urandom(), 1));
			end
		join

		drain();
		$display("Run covered %0d pixels and %0d frame results over %0d threshold sets.",
			pixels_seen, frames_seen, thresh_sets);
		$display("Idling: none, sparse sender, stalled receiver, light on both; one long hold-off.");
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[hsv_color_light_classifier.f]
hdl/hsvc_pkg.sv
hdl/hsvc_fifo.sv
hdl/hsvc_front.sv
hdl/hsvc_back.sv
hdl/hsv_color_light_classifier.sv
sim/hsvc_frame_checker.sv
sim/hsv_color_light_classifier_tb.sv
